// ===== hw/rtl/fsf_pkg.sv =====
package fsf_pkg;

    // Segment codes: bit0 is segment a, bit6 is segment g, bit7 is the colon.
    localparam logic [7:0] SEG_BLANK = 8'h00;
    localparam logic [7:0] SEG_MINUS = 8'h40;
    localparam logic [7:0] SEG_COLON = 8'h80;

    // Display limits in number and time mode.
    localparam logic [13:0] NUM_POS_MAX = 14'd9999;
    localparam logic [16:0] NUM_NEG_MAX = 17'd999;
    localparam logic [7:0]  MIN_MAX     = 8'd99;
    localparam logic [7:0]  SEC_MAX     = 8'd59;

    // Request after clamping, ahead of the digit split.
    typedef struct packed {
        logic        time_mode;
        logic        neg;
        logic        keep_zeros;
        logic        colon;
        logic [13:0] mag;
        logic [6:0]  min;
        logic [5:0]  sec;
    } clamp_t;

    // Request as four decimal digits, leftmost first.
    typedef struct packed {
        logic       time_mode;
        logic       neg;
        logic       keep_zeros;
        logic       colon;
        logic [3:0] d3;
        logic [3:0] d2;
        logic [3:0] d1;
        logic [3:0] d0;
    } digits_t;

    // Seven-segment font for one decimal digit; codes above nine are blank.
    function automatic logic [7:0] font(input logic [3:0] d);
        logic [7:0] code;
        begin
            case (d)
                4'd0:    code = 8'h3F;
                4'd1:    code = 8'h06;
                4'd2:    code = 8'h5B;
                4'd3:    code = 8'h4F;
                4'd4:    code = 8'h66;
                4'd5:    code = 8'h6D;
                4'd6:    code = 8'h7D;
                4'd7:    code = 8'h07;
                4'd8:    code = 8'h7F;
                4'd9:    code = 8'h6F;
                default: code = SEG_BLANK;
            endcase
            return code;
        end
    endfunction

endpackage

// ===== hw/rtl/fsf_clamp.sv =====
module fsf_clamp (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  logic                op,
    input  logic signed [15:0]  value,
    input  logic                zero_fill,
    input  logic [7:0]          minutes,
    input  logic [7:0]          seconds,
    input  logic                colon_lit,
    output logic                out_valid,
    input  logic                out_ready,
    output fsf_pkg::clamp_t     out_data
);

    logic             valid_reg;
    fsf_pkg::clamp_t  data_reg;
    fsf_pkg::clamp_t  data_next;
    logic [15:0]      bits;
    logic [16:0]      neg_mag;

    // The stage takes a new transaction when empty or when it empties now.
    assign in_ready = !valid_reg || out_ready;

    // Clamp the number to -999..9999 and the time to 99:59.
    always_comb
    begin
        bits    = $unsigned(value);
        neg_mag = 17'h10000 - {1'b0, bits};
        data_next.time_mode  = op;
        data_next.neg        = bits[15];
        data_next.keep_zeros = zero_fill;
        data_next.colon      = colon_lit;
        if (bits[15])
        begin
            data_next.mag = (neg_mag > fsf_pkg::NUM_NEG_MAX) ?
                            14'(fsf_pkg::NUM_NEG_MAX) : neg_mag[13:0];
        end
        else
        begin
            data_next.mag = ({1'b0, bits} > {3'b000, fsf_pkg::NUM_POS_MAX}) ?
                            fsf_pkg::NUM_POS_MAX : bits[13:0];
        end
        data_next.min = (minutes > fsf_pkg::MIN_MAX) ? fsf_pkg::MIN_MAX[6:0] : minutes[6:0];
        data_next.sec = (seconds > fsf_pkg::SEC_MAX) ? fsf_pkg::SEC_MAX[5:0] : seconds[5:0];
    end

    // Valid bit under reset.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            valid_reg <= in_valid;
        end
    end

    // Payload register.
    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            data_reg <= data_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;

    // A negative number keeps at most three digits of magnitude.
    assert property (@(posedge clk) disable iff (!rst_n)
        valid_reg && data_reg.neg |-> data_reg.mag <= 14'd999)
        else $error("negative magnitude beyond three digits");

    // Clamped fields stay inside the display range.
    assert property (@(posedge clk) disable iff (!rst_n)
        valid_reg |-> data_reg.mag <= fsf_pkg::NUM_POS_MAX && data_reg.min <= 7'd99
                      && data_reg.sec <= 6'd59)
        else $error("clamped field out of range");

endmodule

// ===== hw/rtl/fsf_split.sv =====
module fsf_split (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  fsf_pkg::clamp_t     in_data,
    output logic                out_valid,
    input  logic                out_ready,
    output fsf_pkg::digits_t    out_data
);

    // First stage: thousands digit and time digits.
    typedef struct packed {
        logic       time_mode;
        logic       neg;
        logic       keep_zeros;
        logic       colon;
        logic [3:0] d3;
        logic [9:0] rem;
        logic [3:0] m_tens;
        logic [3:0] m_ones;
        logic [3:0] s_tens;
        logic [3:0] s_ones;
    } split_a_t;

    // Second stage: hundreds digit.
    typedef struct packed {
        logic       time_mode;
        logic       neg;
        logic       keep_zeros;
        logic       colon;
        logic [3:0] d3;
        logic [3:0] d2;
        logic [6:0] rem;
        logic [3:0] m_tens;
        logic [3:0] m_ones;
        logic [3:0] s_tens;
        logic [3:0] s_ones;
    } split_b_t;

    logic             valid_a_reg;
    logic             valid_b_reg;
    logic             valid_c_reg;
    logic             en_a;
    logic             en_b;
    logic             en_c;
    split_a_t         a_reg;
    split_a_t         a_next;
    split_b_t         b_reg;
    split_b_t         b_next;
    fsf_pkg::digits_t c_reg;
    fsf_pkg::digits_t c_next;
    logic [27:0]      prod_k;
    logic [15:0]      prod_h;
    logic [14:0]      prod_t;
    logic [14:0]      prod_m;
    logic [14:0]      prod_s;
    logic [3:0]       q1;

    // Each stage moves when empty or when the stage after it moves.
    assign en_c     = !valid_c_reg || out_ready;
    assign en_b     = !valid_b_reg || en_c;
    assign en_a     = !valid_a_reg || en_b;
    assign in_ready = en_a;

    // Thousands: mag * 8389 / 2^23 is exact below 10000.
    // Time: x * 205 / 2^11 divides by ten exactly below 1029.
    always_comb
    begin
        prod_k = 28'(in_data.mag) * 28'd8389;
        prod_m = 15'(in_data.min) * 15'd205;
        prod_s = 15'(in_data.sec) * 15'd205;
        a_next.time_mode  = in_data.time_mode;
        a_next.neg        = in_data.neg;
        a_next.keep_zeros = in_data.keep_zeros;
        a_next.colon      = in_data.colon;
        a_next.d3         = prod_k[26:23];
        a_next.rem        = 10'(in_data.mag - ({10'd0, a_next.d3} << 10)
                            + ({10'd0, a_next.d3} << 4) + ({10'd0, a_next.d3} << 3));
        a_next.m_tens     = prod_m[14:11];
        a_next.m_ones     = 4'(in_data.min - ({3'd0, a_next.m_tens} << 3)
                            - ({3'd0, a_next.m_tens} << 1));
        a_next.s_tens     = prod_s[14:11];
        a_next.s_ones     = 4'(in_data.sec - ({2'd0, a_next.s_tens} << 3)
                            - ({2'd0, a_next.s_tens} << 1));
    end

    // Hundreds: rem * 41 / 2^12 is exact below 1000.
    always_comb
    begin
        prod_h = 16'(a_reg.rem) * 16'd41;
        b_next.time_mode  = a_reg.time_mode;
        b_next.neg        = a_reg.neg;
        b_next.keep_zeros = a_reg.keep_zeros;
        b_next.colon      = a_reg.colon;
        b_next.d3         = a_reg.d3;
        b_next.d2         = prod_h[15:12];
        b_next.rem        = 7'(a_reg.rem - ({6'd0, b_next.d2} << 6)
                            - ({6'd0, b_next.d2} << 5) - ({6'd0, b_next.d2} << 2));
        b_next.m_tens     = a_reg.m_tens;
        b_next.m_ones     = a_reg.m_ones;
        b_next.s_tens     = a_reg.s_tens;
        b_next.s_ones     = a_reg.s_ones;
    end

    // Tens and ones, then the choice between number and time digits.
    always_comb
    begin
        prod_t = 15'(b_reg.rem) * 15'd205;
        q1     = prod_t[14:11];
        c_next.time_mode  = b_reg.time_mode;
        c_next.neg        = b_reg.neg;
        c_next.keep_zeros = b_reg.keep_zeros;
        c_next.colon      = b_reg.colon;
        if (b_reg.time_mode)
        begin
            c_next.d3 = b_reg.m_tens;
            c_next.d2 = b_reg.m_ones;
            c_next.d1 = b_reg.s_tens;
            c_next.d0 = b_reg.s_ones;
        end
        else
        begin
            c_next.d3 = b_reg.d3;
            c_next.d2 = b_reg.d2;
            c_next.d1 = q1;
            c_next.d0 = 4'(b_reg.rem - ({3'd0, q1} << 3) - ({3'd0, q1} << 1));
        end
    end

    // Valid bits under reset.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_a_reg <= 1'b0;
            valid_b_reg <= 1'b0;
            valid_c_reg <= 1'b0;
        end
        else
        begin
            if (en_a)
            begin
                valid_a_reg <= in_valid;
            end
            if (en_b)
            begin
                valid_b_reg <= valid_a_reg;
            end
            if (en_c)
            begin
                valid_c_reg <= valid_b_reg;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        if (en_a && in_valid)
        begin
            a_reg <= a_next;
        end
        if (en_b && valid_a_reg)
        begin
            b_reg <= b_next;
        end
        if (en_c && valid_b_reg)
        begin
            c_reg <= c_next;
        end
    end

    assign out_valid = valid_c_reg;
    assign out_data  = c_reg;

    // Quotient estimates never overshoot: remainders stay below their divisor.
    assert property (@(posedge clk) disable iff (!rst_n)
        valid_a_reg |-> a_reg.rem <= 10'd999 && a_reg.d3 <= 4'd9)
        else $error("thousands split out of range");

    // Every digit handed on is a decimal digit.
    assert property (@(posedge clk) disable iff (!rst_n)
        valid_c_reg |-> c_reg.d3 <= 4'd9 && c_reg.d2 <= 4'd9 && c_reg.d1 <= 4'd9
                        && c_reg.d0 <= 4'd9)
        else $error("digit above nine");

endmodule

// ===== hw/rtl/fsf_encode.sv =====
module fsf_encode (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  fsf_pkg::digits_t    in_data,
    output logic                out_valid,
    input  logic                out_ready,
    output logic [7:0]          seg_left,
    output logic [7:0]          seg_mid_left,
    output logic [7:0]          seg_mid_right,
    output logic [7:0]          seg_right
);

    logic       valid_reg;
    logic [7:0] seg0_reg;
    logic [7:0] seg1_reg;
    logic [7:0] seg2_reg;
    logic [7:0] seg3_reg;
    logic [7:0] seg0_next;
    logic [7:0] seg1_next;
    logic [7:0] seg2_next;
    logic [7:0] seg3_next;
    logic       blank0;
    logic       blank1;
    logic       blank2;

    assign in_ready = !valid_reg || out_ready;

    // Font lookup, minus sign, leading-zero blanking and the colon.
    always_comb
    begin
        blank0 = !in_data.time_mode && !in_data.keep_zeros && !in_data.neg
                 && (in_data.d3 == 4'd0);
        blank1 = !in_data.time_mode && !in_data.keep_zeros
                 && (in_data.neg || blank0) && (in_data.d2 == 4'd0);
        blank2 = blank1 && (in_data.d1 == 4'd0);

        seg0_next = fsf_pkg::font(in_data.d3);
        seg1_next = fsf_pkg::font(in_data.d2);
        seg2_next = fsf_pkg::font(in_data.d1);
        seg3_next = fsf_pkg::font(in_data.d0);
        if (!in_data.time_mode && in_data.neg)
        begin
            seg0_next = fsf_pkg::SEG_MINUS;
        end
        if (blank0)
        begin
            seg0_next = fsf_pkg::SEG_BLANK;
        end
        if (blank1)
        begin
            seg1_next = fsf_pkg::SEG_BLANK;
        end
        if (blank2)
        begin
            seg2_next = fsf_pkg::SEG_BLANK;
        end
        if (in_data.time_mode && in_data.colon)
        begin
            seg1_next = seg1_next | fsf_pkg::SEG_COLON;
        end
    end

    // Output valid under reset.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            valid_reg <= in_valid;
        end
    end

    // Output payload register.
    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            seg0_reg <= seg0_next;
            seg1_reg <= seg1_next;
            seg2_reg <= seg2_next;
            seg3_reg <= seg3_next;
        end
    end

    assign out_valid     = valid_reg;
    assign seg_left      = seg0_reg;
    assign seg_mid_left  = seg1_reg;
    assign seg_mid_right = seg2_reg;
    assign seg_right     = seg3_reg;

    // The rightmost digit is never blank.
    assert property (@(posedge clk) disable iff (!rst_n)
        valid_reg |-> seg3_reg != fsf_pkg::SEG_BLANK)
        else $error("rightmost digit blanked");

endmodule

// ===== hw/rtl/four_digit_seven_segment_formatter.sv =====
// Channel   Handshake            Payload
// input     in_valid, in_ready   op, value, zero_fill, minutes, seconds, colon_lit
// output    out_valid, out_ready seg_left, seg_mid_left, seg_mid_right, seg_right
//
// Every transaction passes five register stages: clamp, thousands digit, hundreds
// digit, tens and ones digits, segment encoding. A new transaction is taken every
// cycle while in_ready is high, so throughput is one per cycle unless stalled.
// Reset clears only the valid bits of the stages; no clearing pass is needed.
// When out_ready is low, stages fill up from the output backward, and in_ready
// falls only when all five stages hold a transaction.
module four_digit_seven_segment_formatter (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  logic                op,
    input  logic signed [15:0]  value,
    input  logic                zero_fill,
    input  logic [7:0]          minutes,
    input  logic [7:0]          seconds,
    input  logic                colon_lit,
    output logic                out_valid,
    input  logic                out_ready,
    output logic [7:0]          seg_left,
    output logic [7:0]          seg_mid_left,
    output logic [7:0]          seg_mid_right,
    output logic [7:0]          seg_right
);

    logic             clamp_valid;
    logic             clamp_ready;
    fsf_pkg::clamp_t  clamp_data;
    logic             digit_valid;
    logic             digit_ready;
    fsf_pkg::digits_t digit_data;

    // Clamp stage.
    fsf_clamp u_clamp (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .op           (op),
        .value        (value),
        .zero_fill    (zero_fill),
        .minutes      (minutes),
        .seconds      (seconds),
        .colon_lit    (colon_lit),
        .out_valid    (clamp_valid),
        .out_ready    (clamp_ready),
        .out_data     (clamp_data)
    );

    // Decimal split stages.
    fsf_split u_split (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (clamp_valid),
        .in_ready  (clamp_ready),
        .in_data   (clamp_data),
        .out_valid (digit_valid),
        .out_ready (digit_ready),
        .out_data  (digit_data)
    );

    // Segment encoding and output register.
    fsf_encode u_encode (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (digit_valid),
        .in_ready      (digit_ready),
        .in_data       (digit_data),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .seg_left      (seg_left),
        .seg_mid_left  (seg_mid_left),
        .seg_mid_right (seg_mid_right),
        .seg_right     (seg_right)
    );

    // Back-pressure at the input only comes from a stalled, full output.
    assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |-> out_valid && !out_ready && clamp_valid && digit_valid)
        else $error("input stalled without a full pipeline");

endmodule
